### rtl/core/tqs_pkg.sv
// ----------------------------------------------------------------------------
// tqs_pkg: shared types and constants of the text quality scorer
// Item and result payloads, counter slots, keyword table and score weights.
// ----------------------------------------------------------------------------
package tqs_pkg;

	// default counter width
	localparam int unsigned COUNT_WIDTH_DEF = 24;

	// keyword window: current byte plus history of earlier bytes
	localparam int unsigned HIST_DEPTH = 11;
	localparam int unsigned WIN_LEN    = HIST_DEPTH + 1;
	localparam int unsigned KEY_BITS   = WIN_LEN * 8;
	localparam int unsigned KEY_NUM    = 14;
	localparam int unsigned GROUP_NUM  = 5;

	// counter slots
	localparam int unsigned COUNT_NUM    = 7;
	localparam int unsigned CNT_CHAR     = 0;
	localparam int unsigned CNT_LETTER   = 1;
	localparam int unsigned CNT_DIGIT    = 2;
	localparam int unsigned CNT_PUNCT    = 3;
	localparam int unsigned CNT_WORD     = 4;
	localparam int unsigned CNT_SENTENCE = 5;
	localparam int unsigned CNT_NEWLINE  = 6;

	// score rules
	localparam int unsigned WORD_MIN       = 30;
	localparam int unsigned SENT_MIN       = 2;
	localparam int unsigned SENT_BONUS_MIN = 4;
	localparam int unsigned NEWLINE_MAX    = 80;
	localparam int unsigned LETTER_PCT     = 55;
	localparam int unsigned WLEN_LO_X2     = 7;
	localparam int unsigned WLEN_HI_X2     = 17;
	localparam int unsigned W_LETTER       = 18;
	localparam int unsigned W_WORDLEN      = 14;
	localparam int unsigned W_SENTENCE     = 12;
	localparam int unsigned W_DIGIT        = 4;
	localparam int unsigned P_PUNCT        = 25;
	localparam int unsigned P_NEWLINE      = 10;
	localparam int unsigned SCORE_MAX      = 100;
	localparam logic [6:0]  THRESH_RESET   = 7'd55;

	// keywords, right aligned: last character in the low byte
	localparam logic [KEY_BITS-1:0] KEY_TEXT [KEY_NUM] = '{
		KEY_BITS'("because"), KEY_BITS'("therefore"), KEY_BITS'("so "),
		KEY_BITS'("example"), KEY_BITS'("for instance"),
		KEY_BITS'("exercise"), KEY_BITS'("answer"), KEY_BITS'("question"),
		KEY_BITS'("step"), KEY_BITS'("first"), KEY_BITS'("then"),
		KEY_BITS'("mistake"), KEY_BITS'("remember"), KEY_BITS'("check")
	};
	localparam logic [3:0] KEY_LEN [KEY_NUM] = '{
		4'd7, 4'd9, 4'd3, 4'd7, 4'd12, 4'd8, 4'd6, 4'd8, 4'd4, 4'd5, 4'd4,
		4'd7, 4'd8, 4'd5
	};
	localparam logic [2:0] KEY_GROUP [KEY_NUM] = '{
		3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
		3'd4, 3'd4, 3'd4
	};
	localparam logic [3:0] GROUP_WEIGHT [GROUP_NUM] = '{
		4'd14, 4'd12, 4'd12, 4'd10, 4'd8
	};

	typedef logic [WIN_LEN-1:0][7:0] window_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [6:0] score;
		logic       keep;
	} out_item_t;

	// groups hit by a keyword that ends at the newest window byte
	function automatic logic [GROUP_NUM-1:0] key_groups(input window_t win);
		logic [GROUP_NUM-1:0] g;
		logic                 hit;
		g = '0;
		for (int k = 0; k < KEY_NUM; k++) begin
			hit = 1'b1;
			for (int j = 0; j < WIN_LEN; j++) begin
				if (j < int'(KEY_LEN[k]) && win[j] != KEY_TEXT[k][j*8 +: 8]) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				g[KEY_GROUP[k]] = 1'b1;
			end
		end
		return g;
	endfunction

endpackage

### rtl/core/tqs_stream_if.sv
// ----------------------------------------------------------------------------
// tqs_stream_if: valid/ready channel
// One payload per transfer, taken when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tqs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/tqs_accum.sv
// ----------------------------------------------------------------------------
// tqs_accum: per-record statistics
// Saturating class counters, word tracking, byte history and keyword flags.
// ----------------------------------------------------------------------------
module tqs_accum #(
	parameter int unsigned COUNT_WIDTH = tqs_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic                                                step,
	input  logic [7:0]                                          char_code,
	input  logic                                                has_char,
	input  logic                                                clear,
	output logic [tqs_pkg::COUNT_NUM-1:0][COUNT_WIDTH-1:0]      counts_next,
	output logic [tqs_pkg::GROUP_NUM-1:0]                       groups_next
);
	import tqs_pkg::*;

	logic [COUNT_NUM-1:0][COUNT_WIDTH-1:0] cnt_q;
	logic [HIST_DEPTH-1:0][7:0]            hist_q, hist_d;
	logic [GROUP_NUM-1:0]                  grp_q;
	logic                                  inside_q, inside_d;
	logic [COUNT_NUM-1:0]                  inc;
	logic                                  is_upper, is_letter, is_digit, is_punct, is_alnum;
	logic [7:0]                            low;
	window_t                               win;

	// byte classes and counter increments
	always_comb begin
		is_upper  = char_code >= 8'h41 && char_code <= 8'h5A;
		is_letter = is_upper || (char_code >= 8'h61 && char_code <= 8'h7A);
		is_digit  = char_code >= 8'h30 && char_code <= 8'h39;
		is_punct  = (char_code >= 8'h21 && char_code <= 8'h2F) ||
			(char_code >= 8'h3A && char_code <= 8'h40) ||
			(char_code >= 8'h5B && char_code <= 8'h60) ||
			(char_code >= 8'h7B && char_code <= 8'h7E);
		is_alnum  = is_letter || is_digit;

		inc               = '0;
		inc[CNT_CHAR]     = has_char;
		inc[CNT_LETTER]   = has_char && is_letter;
		inc[CNT_DIGIT]    = has_char && is_digit;
		inc[CNT_PUNCT]    = has_char && is_punct;
		inc[CNT_WORD]     = has_char && is_alnum && !inside_q;
		inc[CNT_SENTENCE] = has_char && (char_code == 8'h2E || char_code == 8'h3F ||
			char_code == 8'h21);
		inc[CNT_NEWLINE]  = has_char && char_code == 8'h0A;

		for (int i = 0; i < COUNT_NUM; i++) begin
			counts_next[i] = (inc[i] && cnt_q[i] != '1) ? cnt_q[i] + 1'b1 : cnt_q[i];
		end
		inside_d = has_char ? is_alnum : inside_q;
	end

	// lowercased window and keyword match
	always_comb begin
		low         = is_upper ? char_code + 8'd32 : char_code;
		win         = {hist_q, low};
		hist_d      = has_char ? win[HIST_DEPTH-1:0] : hist_q;
		groups_next = has_char ? (grp_q | key_groups(win)) : grp_q;
	end

	// state update, cleared after the last item of a record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			hist_q   <= '0;
			grp_q    <= '0;
			inside_q <= 1'b0;
		end else if (step) begin
			if (clear) begin
				cnt_q    <= '0;
				hist_q   <= '0;
				grp_q    <= '0;
				inside_q <= 1'b0;
			end else begin
				cnt_q    <= counts_next;
				hist_q   <= hist_d;
				grp_q    <= groups_next;
				inside_q <= inside_d;
			end
		end
	end

	// end of record leaves clean state
	assert property (@(posedge clk) disable iff (!arst_n)
		step && clear |=> cnt_q == '0 && grp_q == '0 && !inside_q)
		else $error("tqs_accum: state not cleared after end of record");

	// letters and digits are subsets of characters
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[CNT_LETTER] <= cnt_q[CNT_CHAR] && cnt_q[CNT_DIGIT] <= cnt_q[CNT_CHAR])
		else $error("tqs_accum: class count above character count");

	// an item without a byte changes no counter
	assert property (@(posedge clk) disable iff (!arst_n)
		step && !has_char && !clear |=> $stable(cnt_q) && $stable(grp_q))
		else $error("tqs_accum: counters moved on an empty item");

endmodule

### rtl/core/tqs_score.sv
// ----------------------------------------------------------------------------
// tqs_score: record score and keep decision
// Integer ratio tests on the record statistics, clamped to 0..100.
// ----------------------------------------------------------------------------
module tqs_score #(
	parameter int unsigned COUNT_WIDTH = tqs_pkg::COUNT_WIDTH_DEF
) (
	input  logic [tqs_pkg::COUNT_NUM-1:0][COUNT_WIDTH-1:0] counts,
	input  logic [tqs_pkg::GROUP_NUM-1:0]                  groups,
	input  logic [6:0]                                     keep_threshold,
	output logic [6:0]                                     score,
	output logic                                           keep
);
	import tqs_pkg::*;

	localparam int unsigned PW = COUNT_WIDTH + 7;

	logic [PW-1:0] chars_w, letters_w, words_w, punct_w;
	logic          gate, letter_ok, wordlen_ok, punct_bad;
	logic [6:0]    pos, diff;
	logic [5:0]    neg;

	// ratio tests by cross multiplication
	always_comb begin
		chars_w   = PW'(counts[CNT_CHAR]);
		letters_w = PW'(counts[CNT_LETTER]);
		words_w   = PW'(counts[CNT_WORD]);
		punct_w   = PW'(counts[CNT_PUNCT]);

		gate       = counts[CNT_WORD] >= COUNT_WIDTH'(WORD_MIN) &&
			counts[CNT_SENTENCE] >= COUNT_WIDTH'(SENT_MIN);
		letter_ok  = letters_w * PW'(SCORE_MAX) > chars_w * PW'(LETTER_PCT);
		wordlen_ok = letters_w * PW'(2) >= words_w * PW'(WLEN_LO_X2) &&
			letters_w * PW'(2) <= words_w * PW'(WLEN_HI_X2);
		// punct > floor(chars / 3) is the same as 3 * punct > chars
		punct_bad  = punct_w * PW'(3) > chars_w;
	end

	// bonus and penalty sums, then clamp
	always_comb begin
		pos = '0;
		neg = '0;
		if (letter_ok) pos = pos + 7'(W_LETTER);
		if (wordlen_ok) pos = pos + 7'(W_WORDLEN);
		if (counts[CNT_SENTENCE] >= COUNT_WIDTH'(SENT_BONUS_MIN)) pos = pos + 7'(W_SENTENCE);
		for (int g = 0; g < GROUP_NUM; g++) begin
			if (groups[g]) pos = pos + 7'(GROUP_WEIGHT[g]);
		end
		if (counts[CNT_DIGIT] != '0) pos = pos + 7'(W_DIGIT);
		if (punct_bad) neg = neg + 6'(P_PUNCT);
		if (counts[CNT_NEWLINE] > COUNT_WIDTH'(NEWLINE_MAX)) neg = neg + 6'(P_NEWLINE);

		diff = pos - 7'(neg);
		if (!gate || pos <= 7'(neg)) begin
			score = '0;
		end else if (diff > 7'(SCORE_MAX)) begin
			score = 7'(SCORE_MAX);
		end else begin
			score = diff;
		end
		keep = score >= keep_threshold;
	end

endmodule

### rtl/core/text_quality_scorer_unit.sv
// ----------------------------------------------------------------------------
// text_quality_scorer_unit: streaming text quality scorer
// Scores one text record, one byte per transfer, with a keep flag.
// ----------------------------------------------------------------------------
// Takes one byte per cycle with no gaps of its own; a record may follow the
// previous one directly. The result of a record is offered once its last
// item has passed through the input register, then the statistics snapshot,
// then the result register. Backpressure on the result side stalls the
// input only once both the snapshot and the result register hold records.
// keep_threshold is written through cfg_wr_en/cfg_wr_data; the user must do
// so only while no record is in flight, as the block does not enforce it.
module text_quality_scorer_unit #(
	parameter int unsigned COUNT_WIDTH = tqs_pkg::COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tqs_stream_if.sink   item,
	tqs_stream_if.source result,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data
);
	import tqs_pkg::*;

	logic                                  valid_s1;
	in_item_t                              item_s1;
	logic                                  valid_s2;
	logic [COUNT_NUM-1:0][COUNT_WIDTH-1:0] counts_s2;
	logic [GROUP_NUM-1:0]                  groups_s2;
	logic                                  out_valid_q;
	out_item_t                             out_q;
	logic [6:0]                            thresh_q;

	logic [COUNT_NUM-1:0][COUNT_WIDTH-1:0] counts_next;
	logic [GROUP_NUM-1:0]                  groups_next;
	logic [6:0]                            score_c;
	logic                                  keep_c;
	logic                                  ready_out, fire_s1, fire_s2, take_in;

	// pipeline flow control
	always_comb begin
		ready_out = !out_valid_q || result.ready;
		fire_s2   = valid_s2 && ready_out;
		fire_s1   = valid_s1 && (!item_s1.end_of_text || !valid_s2 || ready_out);
		take_in   = item.valid && item.ready;
	end
	assign item.ready     = !valid_s1 || fire_s1;
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// record statistics
	tqs_accum #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (fire_s1),
		.char_code   (item_s1.char_code),
		.has_char    (item_s1.has_char),
		.clear       (item_s1.end_of_text),
		.counts_next (counts_next),
		.groups_next (groups_next)
	);

	// score of the snapshot
	tqs_score #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_score (
		.counts         (counts_s2),
		.groups         (groups_s2),
		.keep_threshold (thresh_q),
		.score          (score_c),
		.keep           (keep_c)
	);

	// valid bits and threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			thresh_q    <= THRESH_RESET;
		end else begin
			if (take_in) valid_s1 <= 1'b1;
			else if (fire_s1) valid_s1 <= 1'b0;

			if (fire_s1 && item_s1.end_of_text) valid_s2 <= 1'b1;
			else if (fire_s2) valid_s2 <= 1'b0;

			if (fire_s2) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;

			if (cfg_wr_en) thresh_q <= cfg_wr_data;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) item_s1 <= item.payload;
		if (fire_s1 && item_s1.end_of_text) begin
			counts_s2 <= counts_next;
			groups_s2 <= groups_next;
		end
		if (fire_s2) begin
			out_q.score <= score_c;
			out_q.keep  <= keep_c;
		end
	end

	// a snapshot moved on always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s2 |=> out_valid_q)
		else $error("text_quality_scorer_unit: snapshot lost");

	// a blocked snapshot stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_out |=> valid_s2 && $stable(counts_s2) && $stable(groups_s2))
		else $error("text_quality_scorer_unit: stalled snapshot changed");

	// a held result never exceeds full score
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.score <= 7'(SCORE_MAX))
		else $error("text_quality_scorer_unit: score out of range");

endmodule
